@@ sv/job_table_engine_defines.svh @@
// Assertion macros shared by the job table engine's checker.
// No dependencies; include this header by its bare file name.
`ifndef JOB_TABLE_ENGINE_DEFINES_SVH
`define JOB_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define JTE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define JTE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/jte_pkg.sv @@
// Shared types and constants for the job table engine.
// No dependencies; the module, checker and testbench files import this package.
package jte_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int OP_W        = 3;
    localparam int JOB_W       = 16;
    localparam int PID_W       = 22;
    localparam int RS_W        = 2;
    localparam int ST_W        = 2;

    localparam logic [JOB_W-1:0] JOB_MAX        = {JOB_W{1'b1}};
    localparam logic [RS_W-1:0]  ACTIVE_CODE    = 2'd0;
    localparam logic [RS_W-1:0]  SUSPENDED_CODE = 2'd1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 3'd0,
        OP_DELETE   = 3'd1,
        OP_EXISTS   = 3'd2,
        OP_PID2JOB  = 3'd3,
        OP_JOB2PID  = 3'd4,
        OP_SUSPEND  = 3'd5,
        OP_ACTIVATE = 3'd6
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EXHAUSTED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE   = 2'd0,
        FSM_SEARCH = 2'd1,
        FSM_EXEC   = 2'd2
    } fsm_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;   // capture the accepted item
        logic search;  // compare all slots and register the hits
        logic exec;    // commit the table update and load the result
    } dp_cmd_t;

endpackage

@@ sv/jte_ctrl.sv @@
// Controller of the job table engine: sequences search and execute.
// Depends on jte_pkg.
module jte_ctrl
    import jte_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    output dp_cmd_t cmd
);

    fsm_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            FSM_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = FSM_SEARCH;
                end
            end
            FSM_SEARCH: begin
                cmd.search = 1'b1;
                state_next = FSM_EXEC;
            end
            FSM_EXEC: begin
                // The result register must be free, or be emptied this cycle.
                if (!m_valid_reg || m_ready) begin
                    cmd.exec   = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase

        if (cmd.exec) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

@@ sv/jte_datapath.sv @@
// Datapath of the job table engine: entry registers, slot compare,
// compaction on delete and the result register. Depends on jte_pkg.
module jte_datapath
    import jte_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  dp_cmd_t          cmd,
    input  logic [OP_W-1:0]  s_op,
    input  logic [JOB_W-1:0] s_key_job,
    input  logic [PID_W-1:0] s_key_pid,
    input  logic [RS_W-1:0]  s_new_state,
    output logic [ST_W-1:0]  m_status,
    output logic             m_found,
    output logic [JOB_W-1:0] m_result_job,
    output logic [PID_W-1:0] m_result_pid
);

    // Latched command.
    logic [OP_W-1:0]  op_reg;
    logic [JOB_W-1:0] kjob_reg;
    logic [PID_W-1:0] kpid_reg;
    logic [RS_W-1:0]  nst_reg;

    // Table storage; slots below the count are in use, in rising job order.
    logic [JOB_W-1:0] job_reg [TABLE_DEPTH];
    logic [PID_W-1:0] pid_reg [TABLE_DEPTH];
    logic [RS_W-1:0]  rs_reg  [TABLE_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;

    // Search results.
    logic [TABLE_DEPTH-1:0] match_reg, match_next;
    logic [JOB_W-1:0]       top_reg, top_next;

    // Result register.
    logic [ST_W-1:0]  status_reg, status_next;
    logic             found_reg, found_next;
    logic [JOB_W-1:0] rjob_reg, rjob_next;
    logic [PID_W-1:0] rpid_reg, rpid_next;

    // Execute-stage decode.
    logic [TABLE_DEPTH-1:0] hit;
    logic [TABLE_DEPTH-1:0] at_or_after;
    logic [TABLE_DEPTH-1:0] add_we;
    logic                   any_hit;
    logic [JOB_W-1:0]       sel_job;
    logic [PID_W-1:0]       sel_pid;
    logic                   do_add, do_delete, do_set_rs;
    logic [RS_W-1:0]        set_code;

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            op_reg   <= s_op;
            kjob_reg <= s_key_job;
            kpid_reg <= s_key_pid;
            nst_reg  <= s_new_state;
        end
    end

    // Search: compare every used slot at once; the largest job is the last slot.
    always_comb begin
        match_next = '0;
        top_next   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (CNT_W'(i) < count_reg) begin
                if (op_t'(op_reg) == OP_PID2JOB) begin
                    match_next[i] = (pid_reg[i] == kpid_reg);
                end else begin
                    match_next[i] = (job_reg[i] == kjob_reg);
                end
            end
            if (CNT_W'(i + 1) == count_reg) begin
                top_next = top_next | job_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.search) begin
            match_reg <= match_next;
            top_reg   <= top_next;
        end
    end

    // Execute: lowest hit wins; select its fields with a one-hot mux.
    always_comb begin
        hit         = match_reg & (~match_reg + TABLE_DEPTH'(1));
        at_or_after = ~(hit - TABLE_DEPTH'(1));
        any_hit     = |match_reg;
        sel_job     = '0;
        sel_pid     = '0;
        add_we      = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (hit[i]) begin
                sel_job = sel_job | job_reg[i];
                sel_pid = sel_pid | pid_reg[i];
            end
            add_we[i] = (CNT_W'(i) == count_reg);
        end

        status_next = ST_OK;
        found_next  = 1'b0;
        rjob_next   = '0;
        rpid_next   = '0;
        count_next  = count_reg;
        do_add      = 1'b0;
        do_delete   = 1'b0;
        do_set_rs   = 1'b0;
        set_code    = ACTIVE_CODE;

        case (op_t'(op_reg))
            OP_ADD: begin
                if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                    status_next = ST_FULL;
                end else if (top_reg == JOB_MAX) begin
                    status_next = ST_EXHAUSTED;
                end else begin
                    do_add     = 1'b1;
                    rjob_next  = JOB_W'(top_reg + JOB_W'(1));
                    count_next = CNT_W'(count_reg + CNT_W'(1));
                end
            end
            OP_DELETE: begin
                if (any_hit) begin
                    found_next = 1'b1;
                    do_delete  = 1'b1;
                    count_next = CNT_W'(count_reg - CNT_W'(1));
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            OP_EXISTS, OP_PID2JOB, OP_JOB2PID, OP_SUSPEND, OP_ACTIVATE: begin
                if (any_hit) begin
                    found_next = 1'b1;
                    if (op_t'(op_reg) == OP_PID2JOB) begin
                        rjob_next = sel_job;
                    end
                    if (op_t'(op_reg) == OP_JOB2PID) begin
                        rpid_next = sel_pid;
                    end
                    if (op_t'(op_reg) == OP_SUSPEND) begin
                        do_set_rs = 1'b1;
                        set_code  = SUSPENDED_CODE;
                    end
                    if (op_t'(op_reg) == OP_ACTIVATE) begin
                        do_set_rs = 1'b1;
                    end
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    // Entry updates: append at the count, shift down on delete, or set state.
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (do_add && add_we[i]) begin
                    job_reg[i] <= rjob_next;
                    pid_reg[i] <= kpid_reg;
                    rs_reg[i]  <= nst_reg;
                end else if (do_delete && at_or_after[i] && (i < TABLE_DEPTH - 1)) begin
                    job_reg[i] <= job_reg[(i + 1) % TABLE_DEPTH];
                    pid_reg[i] <= pid_reg[(i + 1) % TABLE_DEPTH];
                    rs_reg[i]  <= rs_reg[(i + 1) % TABLE_DEPTH];
                end else if (do_set_rs && hit[i]) begin
                    rs_reg[i] <= set_code;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.exec) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg <= status_next;
            found_reg  <= found_next;
            rjob_reg   <= rjob_next;
            rpid_reg   <= rpid_next;
        end
    end

    assign m_status     = status_reg;
    assign m_found      = found_reg;
    assign m_result_job = rjob_reg;
    assign m_result_pid = rpid_reg;

endmodule

@@ sv/job_table_engine.sv @@
// Top level of the job table engine: controller plus datapath.
// Depends on jte_pkg, jte_ctrl and jte_datapath.
//
//   Channel  | Direction | Handshake          | Payload
//   ---------+-----------+--------------------+----------------------------------------
//   s_       | in        | s_valid / s_ready  | s_op, s_key_job, s_key_pid, s_new_state
//   m_       | out       | m_valid / m_ready  | m_status, m_found, m_result_job,
//            |           |                    | m_result_pid
//
// Each item passes through accept, a search step that compares every table
// slot in parallel, and an execute step that updates the table and loads
// the result register. A new item is taken only after the last one has left
// execute, even while the previous result still waits in the result
// register; execute holds only while that register is full and m_ready is low.
// Reset (aresetn, synchronous, active low) empties the table and the result.
module job_table_engine
    import jte_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [OP_W-1:0]  s_op,
    input  logic [JOB_W-1:0] s_key_job,
    input  logic [PID_W-1:0] s_key_pid,
    input  logic [RS_W-1:0]  s_new_state,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [ST_W-1:0]  m_status,
    output logic             m_found,
    output logic [JOB_W-1:0] m_result_job,
    output logic [PID_W-1:0] m_result_pid
);

    // Command bundle from the controller to the datapath.
    dp_cmd_t cmd;

    // The controller owns the handshakes and steps each item through
    // its search and execute cycles.
    jte_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // The datapath holds the table, does the slot compares, compacts the
    // table on delete and keeps the result payload.
    jte_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_op         (s_op),
        .s_key_job    (s_key_job),
        .s_key_pid    (s_key_pid),
        .s_new_state  (s_new_state),
        .m_status     (m_status),
        .m_found      (m_found),
        .m_result_job (m_result_job),
        .m_result_pid (m_result_pid)
    );

endmodule

@@ sv/jte_checker.sv @@
// Port-level checks for the job table engine, bound to the top level.
// Depends on jte_pkg and job_table_engine_defines.svh.
`include "job_table_engine_defines.svh"

module jte_checker
    import jte_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic [OP_W-1:0]  s_op,
    input logic [JOB_W-1:0] s_key_job,
    input logic [PID_W-1:0] s_key_pid,
    input logic [RS_W-1:0]  s_new_state,
    input logic             m_valid,
    input logic             m_ready,
    input logic [ST_W-1:0]  m_status,
    input logic             m_found,
    input logic [JOB_W-1:0] m_result_job,
    input logic [PID_W-1:0] m_result_pid
);

    // A stalled result keeps its payload.
    `JTE_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_found) && $stable(m_result_job) && $stable(m_result_pid), "result changed while stalled")

    // The engine works on one item at a time.
    `JTE_ASSERT_NXT(a_one_item, s_valid && s_ready, !s_ready, "item accepted while busy")

    // A found entry always reports success.
    `JTE_ASSERT_IMP(a_found_ok, m_valid && m_found, m_status == ST_OK, "found with error status")

    // Failed commands return zero result fields.
    `JTE_ASSERT_IMP(a_err_zero, m_valid && (m_status != ST_OK), (m_result_job == '0) && (m_result_pid == '0) && !m_found, "error result not zeroed")

endmodule

bind job_table_engine jte_checker u_jte_checker (.*);

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for job_table_engine: directed and random job commands,
// each reply checked against a behavioral job table updated per accepted item.
// Depends on jte_pkg and the job_table_engine RTL.
module tb_top;
    import jte_pkg::*;

    // Op code 7 has no enum member in the package; the block must ignore it.
    localparam logic [OP_W-1:0]  OP_UNUSED     = 3'd7;
    localparam logic [PID_W-1:0] PID_MAX       = {PID_W{1'b1}};
    localparam int               CYCLE_LIMIT   = 4_000_000;
    localparam int               SETTLE_CYCLES = 10;
    localparam int               LONG_HOLD     = 120;
    localparam int               HOLD_AFTER    = 300;
    localparam int               QUEUE_AHEAD   = 4;
    localparam int               SEGMENTS      = 12;
    localparam int               SEG_ITEMS     = 150;

    // One pending command. A pause entry carries no command: the sender
    // stops at it until every reply that is owed has come back.
    typedef struct packed {
        logic             pause;
        logic [OP_W-1:0]  op;
        logic [JOB_W-1:0] job;
        logic [PID_W-1:0] pid;
        logic [RS_W-1:0]  run_state;
    } job_cmd_t;

    typedef struct packed {
        status_t          status;
        logic             found;
        logic [JOB_W-1:0] job;
        logic [PID_W-1:0] pid;
    } job_reply_t;

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic             s_ready;
    logic [OP_W-1:0]  s_op        = '0;
    logic [JOB_W-1:0] s_key_job   = '0;
    logic [PID_W-1:0] s_key_pid   = '0;
    logic [RS_W-1:0]  s_new_state = '0;
    logic             m_valid;
    logic             m_ready     = 1'b0;
    logic [ST_W-1:0]  m_status;
    logic             m_found;
    logic [JOB_W-1:0] m_result_job;
    logic [PID_W-1:0] m_result_pid;

    always #1 aclk = ~aclk;

    job_table_engine i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_key_job    (s_key_job),
        .s_key_pid    (s_key_pid),
        .s_new_state  (s_new_state),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found      (m_found),
        .m_result_job (m_result_job),
        .m_result_pid (m_result_pid)
    );

    // ------------------------------------------------------------------
    // Behavioral job table. Entries 0 .. held_jobs-1 are live and packed
    // with no gaps; it advances once per item accepted by the block.
    // ------------------------------------------------------------------
    logic [JOB_W-1:0] tbl_job   [TABLE_DEPTH];
    logic [PID_W-1:0] tbl_pid   [TABLE_DEPTH];
    logic [RS_W-1:0]  tbl_state [TABLE_DEPTH];
    int               held_jobs = 0;

    job_cmd_t   cmd_queue [$];
    job_reply_t results_due [$];
    job_cmd_t   next_cmd;
    job_reply_t want;
    job_reply_t got;
    logic [PID_W-1:0] pid_pool [8];

    int   items_pushed = 0;
    int   items_taken  = 0;
    int   results_seen = 0;
    int   mismatches   = 0;
    int   cycle_count  = 0;
    int   gap_left     = 0;
    int   hold_left    = 0;
    logic in_taken       = 1'b0;
    logic long_hold_done = 1'b0;
    logic tx_gaps        = 1'b0;
    logic rx_stalls      = 1'b0;
    int   status_seen [4] = '{default: 0};
    int   op_seen     [8] = '{default: 0};

    // First live slot holding this job number, or -1.
    function automatic int job_slot(logic [JOB_W-1:0] job);
        for (int i = 0; i < held_jobs; i++) begin
            if (tbl_job[i] == job) begin
                return i;
            end
        end
        return -1;
    endfunction

    // First live slot holding this process id, or -1.
    function automatic int pid_slot(logic [PID_W-1:0] pid);
        for (int i = 0; i < held_jobs; i++) begin
            if (tbl_pid[i] == pid) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one command to the table and returns the reply it must produce.
    function automatic job_reply_t apply_job_command(job_cmd_t c);
        job_reply_t       r;
        logic [JOB_W-1:0] top;
        int               slot;
        r = '{status: ST_OK, found: 1'b0, job: '0, pid: '0};
        case (c.op)
            OP_ADD: begin
                // A full table is reported before exhausted job numbers.
                if (held_jobs >= TABLE_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    top = '0;
                    for (int i = 0; i < held_jobs; i++) begin
                        if (tbl_job[i] > top) begin
                            top = tbl_job[i];
                        end
                    end
                    if (top == JOB_MAX) begin
                        r.status = ST_EXHAUSTED;
                    end else begin
                        tbl_job[held_jobs]   = top + 1'b1;
                        tbl_pid[held_jobs]   = c.pid;
                        tbl_state[held_jobs] = c.run_state;
                        held_jobs++;
                        r.job = top + 1'b1;
                    end
                end
            end
            OP_DELETE: begin
                slot = job_slot(c.job);
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.found = 1'b1;
                    // Close the gap: later entries move down one slot.
                    for (int i = slot; i < held_jobs - 1; i++) begin
                        tbl_job[i]   = tbl_job[i + 1];
                        tbl_pid[i]   = tbl_pid[i + 1];
                        tbl_state[i] = tbl_state[i + 1];
                    end
                    held_jobs--;
                end
            end
            OP_EXISTS: begin
                slot = job_slot(c.job);
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.found = 1'b1;
                end
            end
            OP_PID2JOB: begin
                slot = pid_slot(c.pid);
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.found = 1'b1;
                    r.job   = tbl_job[slot];
                end
            end
            OP_JOB2PID: begin
                slot = job_slot(c.job);
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.found = 1'b1;
                    r.pid   = tbl_pid[slot];
                end
            end
            OP_SUSPEND, OP_ACTIVATE: begin
                // The run state never shows on the outputs, but it is kept
                // so the table stays a faithful image of the block.
                slot = job_slot(c.job);
                if (slot < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.found = 1'b1;
                    tbl_state[slot] = (c.op == OP_SUSPEND) ? SUSPENDED_CODE : ACTIVE_CODE;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Job keys mostly hit live entries, otherwise small or fully random.
    function automatic logic [JOB_W-1:0] pick_job_key();
        if (held_jobs > 0 && $urandom_range(0, 3) != 0) begin
            return tbl_job[$urandom_range(0, held_jobs - 1)];
        end else if ($urandom_range(0, 1) == 0) begin
            return $urandom_range(0, 40);
        end
        return $urandom_range(0, JOB_MAX);
    endfunction

    // Process ids come from live entries and a small pool, so duplicates
    // and hits are common, with a share of fully random ones.
    function automatic logic [PID_W-1:0] pick_pid_key();
        int r;
        r = $urandom_range(0, 3);
        if (r < 2 && held_jobs > 0) begin
            return tbl_pid[$urandom_range(0, held_jobs - 1)];
        end else if (r < 3) begin
            return pid_pool[$urandom_range(0, 7)];
        end
        return $urandom_range(0, PID_MAX);
    endfunction

    // ------------------------------------------------------------------
    // Checker. Replies are compared first and accepted items predicted
    // second, so the order within the clock edge is fixed.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            got = '{status: status_t'(m_status), found: m_found,
                    job: m_result_job, pid: m_result_pid};
            status_seen[m_status]++;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("reply %0d arrived with nothing owed: status %0d found %0d",
                             results_seen, m_status, m_found);
                end
            end else begin
                want = results_due.pop_front();
                if (got.status != want.status || got.found != want.found ||
                    got.job != want.job || got.pid != want.pid) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("reply %0d wrong (expected/actual): status %0d/%0d",
                                 results_seen, want.status, got.status);
                        $display("    found %0d/%0d job %0d/%0d pid %0d/%0d",
                                 want.found, got.found, want.job, got.job,
                                 want.pid, got.pid);
                    end
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            results_due.push_back(apply_job_command(
                '{pause: 1'b0, op: s_op, job: s_key_job, pid: s_key_pid,
                  run_state: s_new_state}));
            op_seen[s_op]++;
            items_taken++;
        end
    end

    // ------------------------------------------------------------------
    // Sender. Moves at the falling edge; a new item is only put up once
    // the previous one was taken, so the payload holds while valid is high.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // Still waiting for the block to take the current item.
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            s_valid  <= 1'b0;
        end else if (cmd_queue.size() == 0) begin
            s_valid <= 1'b0;
        end else if (cmd_queue[0].pause) begin
            s_valid <= 1'b0;
            if (results_due.size() == 0) begin
                void'(cmd_queue.pop_front());
            end
        end else begin
            next_cmd    = cmd_queue.pop_front();
            s_op        <= next_cmd.op;
            s_key_job   <= next_cmd.job;
            s_key_pid   <= next_cmd.pid;
            s_new_state <= next_cmd.run_state;
            s_valid     <= 1'b1;
            gap_left    <= tx_gaps ? pick_gap() : 0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver. Random stalls, plus one long hold-off once a few hundred
    // replies are in, so the block backs up and drops s_ready.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            m_ready        <= 1'b0;
        end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
            hold_left <= pick_gap();
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies still owed",
                     cycle_count, results_due.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // Queues one command, keeping only a few ahead of the sender so that
    // key choices follow the table closely.
    task automatic send(input logic [OP_W-1:0] op, input logic [JOB_W-1:0] job,
                        input logic [PID_W-1:0] pid, input logic [RS_W-1:0] st);
        while (cmd_queue.size() >= QUEUE_AHEAD) begin
            @(negedge aclk);
        end
        cmd_queue.push_back('{pause: 1'b0, op: op, job: job, pid: pid, run_state: st});
        items_pushed++;
    endtask

    // Waits until every queued item was taken and every reply came back.
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (items_taken != items_pushed || results_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Stimulus: directed cases, random segments, then a fill of the
    // emptied table up to full and a few adds and deletes around it.
    // ------------------------------------------------------------------
    initial begin
        logic [OP_W-1:0]  op;
        logic [JOB_W-1:0] snap_jobs [TABLE_DEPTH];
        int               snap_count;
        int               add_pct;
        int               del_pct;
        int               pick;

        pid_pool[0] = '0;
        pid_pool[1] = PID_MAX;
        for (int i = 2; i < 8; i++) begin
            pid_pool[i] = $urandom_range(0, PID_MAX);
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: misses on an empty table, the unused op, adds with
        // extreme and duplicate pids, lookups, updates and deletes that
        // close the gap at the front and at the end.
        send(OP_DELETE,   16'd5,   '0,            2'd0);
        send(OP_EXISTS,   16'd0,   '0,            2'd0);
        send(OP_PID2JOB,  16'd0,   '0,            2'd0);
        send(OP_JOB2PID,  JOB_MAX, PID_MAX,       2'd3);
        send(OP_SUSPEND,  16'd1,   '0,            2'd0);
        send(OP_UNUSED,   16'd0,   '0,            2'd0);
        send(OP_ADD,      16'd0,   '0,            2'd0);
        send(OP_ADD,      JOB_MAX, PID_MAX,       2'd3);
        send(OP_ADD,      16'd0,   22'h155555,    2'd1);
        send(OP_ADD,      16'd0,   '0,            2'd2);
        send(OP_PID2JOB,  16'd0,   '0,            2'd0);
        send(OP_PID2JOB,  16'd0,   PID_MAX,       2'd0);
        send(OP_JOB2PID,  16'd2,   '0,            2'd0);
        send(OP_EXISTS,   16'd3,   '0,            2'd0);
        send(OP_EXISTS,   JOB_MAX, '0,            2'd0);
        send(OP_SUSPEND,  16'd2,   '0,            2'd0);
        send(OP_ACTIVATE, 16'd2,   '0,            2'd0);
        send(OP_ACTIVATE, 16'd0,   '0,            2'd0);
        send(OP_DELETE,   16'd1,   '0,            2'd0);
        send(OP_PID2JOB,  16'd0,   '0,            2'd0);
        send(OP_DELETE,   16'd4,   '0,            2'd0);
        send(OP_ADD,      16'd0,   22'h2aaaaa,    2'd2);
        send(OP_UNUSED,   JOB_MAX, PID_MAX,       2'd3);

        // Random segments, each with its own add/delete balance so the
        // table both fills up and runs dry. Segment 1 never idles the
        // sender, which keeps items coming during the long hold-off.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            add_pct   = $urandom_range(20, 60);
            del_pct   = $urandom_range(10, 30);
            tx_gaps   = (seg == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            rx_stalls = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < SEG_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < add_pct) begin
                    op = OP_ADD;
                end else if (pick < add_pct + del_pct) begin
                    op = OP_DELETE;
                end else if (pick >= 97) begin
                    op = OP_UNUSED;
                end else begin
                    case ($urandom_range(0, 4))
                        0: begin
                            op = OP_EXISTS;
                        end
                        1: begin
                            op = OP_PID2JOB;
                        end
                        2: begin
                            op = OP_JOB2PID;
                        end
                        3: begin
                            op = OP_SUSPEND;
                        end
                        default: begin
                            op = OP_ACTIVATE;
                        end
                    endcase
                end
                send(op, pick_job_key(), pick_pid_key(), $urandom_range(0, 3));
            end
            // The sender sometimes stops until all replies are back.
            if (seg == 0 || $urandom_range(0, 2) == 0) begin
                cmd_queue.push_back('{pause: 1'b1, default: '0});
            end
        end

        // Fill: empty the table, then add jobs 1 .. TABLE_DEPTH back to
        // back; one more add finds the table full.
        wait_idle();
        tx_gaps    = 1'b0;
        rx_stalls  = 1'b0;
        snap_count = held_jobs;
        for (int i = 0; i < snap_count; i++) begin
            snap_jobs[i] = tbl_job[i];
        end
        for (int i = 0; i < snap_count; i++) begin
            send(OP_DELETE, snap_jobs[i], $urandom_range(0, PID_MAX), 2'd0);
        end
        wait_idle();
        for (int k = 0; k <= TABLE_DEPTH; k++) begin
            send(OP_ADD, '0, $urandom_range(0, PID_MAX), $urandom_range(0, 3));
        end
        // Dropping a middle job makes room, and the add after it takes the
        // number one above the largest. Dropping the largest job makes its
        // number available again.
        send(OP_DELETE,  16'd8,  '0,      2'd0);
        send(OP_ADD,     '0,     '0,      2'd1);
        send(OP_JOB2PID, 16'd17, '0,      2'd0);
        send(OP_DELETE,  16'd17, '0,      2'd0);
        send(OP_ADD,     '0,     PID_MAX, 2'd3);
        send(OP_EXISTS,  16'd17, '0,      2'd0);

        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("ran %0d items: %0d ok, %0d not found, %0d full, %0d out of job numbers",
                 items_taken, status_seen[ST_OK], status_seen[ST_NOT_FOUND],
                 status_seen[ST_FULL], status_seen[ST_EXHAUSTED]);
        $display("adds %0d, deletes %0d, lookups %0d, updates %0d, unused op %0d, %0d bad",
                 op_seen[OP_ADD], op_seen[OP_DELETE],
                 op_seen[OP_EXISTS] + op_seen[OP_PID2JOB] + op_seen[OP_JOB2PID],
                 op_seen[OP_SUSPEND] + op_seen[OP_ACTIVATE], op_seen[OP_UNUSED],
                 mismatches);
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/jte_pkg.sv
sv/jte_ctrl.sv
sv/jte_datapath.sv
sv/job_table_engine.sv
sv/jte_checker.sv
test/tb_top.sv
